/* rtl/mve_pkg.sv */
`default_nettype none
package mve_pkg;

    typedef enum logic [3:0] {
        OP_NIL     = 4'd0,
        OP_TRUE    = 4'd1,
        OP_FALSE   = 4'd2,
        OP_INT     = 4'd3,
        OP_STR     = 4'd4,
        OP_BIN     = 4'd5,
        OP_MAP     = 4'd6,
        OP_ARRAY   = 4'd7,
        OP_PAYLOAD = 4'd8
    } t_op;

    localparam logic [7:0] LEAD_NIL     = 8'hC0;
    localparam logic [7:0] LEAD_FALSE   = 8'hC2;
    localparam logic [7:0] LEAD_TRUE    = 8'hC3;
    localparam logic [7:0] LEAD_BIN8    = 8'hC4;
    localparam logic [7:0] LEAD_BIN16   = 8'hC5;
    localparam logic [7:0] LEAD_BIN32   = 8'hC6;
    localparam logic [7:0] LEAD_INT8    = 8'hD0;
    localparam logic [7:0] LEAD_INT16   = 8'hD1;
    localparam logic [7:0] LEAD_INT32   = 8'hD2;
    localparam logic [7:0] LEAD_INT64   = 8'hD3;
    localparam logic [7:0] LEAD_STR16   = 8'hDA;
    localparam logic [7:0] LEAD_STR32   = 8'hDB;
    localparam logic [7:0] LEAD_ARR16   = 8'hDC;
    localparam logic [7:0] LEAD_ARR32   = 8'hDD;
    localparam logic [7:0] LEAD_MAP16   = 8'hDE;
    localparam logic [7:0] LEAD_MAP32   = 8'hDF;
    localparam logic [7:0] BASE_FIXSTR  = 8'hA0;
    localparam logic [7:0] BASE_FIXMAP  = 8'h80;
    localparam logic [7:0] BASE_FIXARR  = 8'h90;
    localparam logic [7:0] BASE_NEGFIX  = 8'hE0;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // lead byte, then body_len bytes taken from the top of body
    typedef struct packed {
        logic [7:0]  lead;
        logic [63:0] body;
        logic [3:0]  body_len;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/mve_front.sv */
`default_nettype none
module mve_front
    import mve_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic [3:0]  i_operation,
    input  wire logic [63:0] i_int_value,
    input  wire logic [31:0] i_length,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_q_full,
    output      logic        o_ready,
    output      logic        o_push,
    output      t_entry      o_entry
);

    function automatic t_entry hdr(
        input logic [31:0] len,
        input logic [31:0] small_max,
        input logic [7:0]  small_base,
        input logic [7:0]  lead16,
        input logic [7:0]  lead32
    );
        t_entry e;
        e.lead     = lead32;
        e.body     = {len, 32'd0};
        e.body_len = 4'd4;
        if (len <= small_max) begin
            e.lead     = small_base + len[7:0];
            e.body     = '0;
            e.body_len = 4'd0;
        end else if (len <= 32'h0000_FFFF) begin
            e.lead     = lead16;
            e.body     = {len[15:0], 48'd0};
            e.body_len = 4'd2;
        end
        return e;
    endfunction

    t_op                op;
    logic signed [63:0] v;
    logic               known;

    assign op      = t_op'(i_operation);
    assign v       = $signed(i_int_value);
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready && known;

    always_comb begin
        known             = 1'b1;
        o_entry.lead      = LEAD_NIL;
        o_entry.body      = '0;
        o_entry.body_len  = 4'd0;
        unique case (op)
            OP_NIL:     o_entry.lead = LEAD_NIL;
            OP_TRUE:    o_entry.lead = LEAD_TRUE;
            OP_FALSE:   o_entry.lead = LEAD_FALSE;
            OP_PAYLOAD: o_entry.lead = i_data_byte;
            OP_INT: begin
                if (v > 64'sd0 && v <= 64'sd127) begin
                    o_entry.lead = {1'b0, i_int_value[6:0]};
                end else if (v < 64'sd0 && v >= -64'sd31) begin
                    o_entry.lead = BASE_NEGFIX | i_int_value[7:0];
                end else if (v >= -64'sd127 && v <= 64'sd127) begin
                    o_entry.lead     = LEAD_INT8;
                    o_entry.body     = {i_int_value[7:0], 56'd0};
                    o_entry.body_len = 4'd1;
                end else if (v >= -64'sd32767 && v <= 64'sd32767) begin
                    o_entry.lead     = LEAD_INT16;
                    o_entry.body     = {i_int_value[15:0], 48'd0};
                    o_entry.body_len = 4'd2;
                end else if (v >= -64'sd2147483648 && v <= 64'sd2147483647) begin
                    o_entry.lead     = LEAD_INT32;
                    o_entry.body     = {i_int_value[31:0], 32'd0};
                    o_entry.body_len = 4'd4;
                end else begin
                    o_entry.lead     = LEAD_INT64;
                    o_entry.body     = i_int_value;
                    o_entry.body_len = 4'd8;
                end
            end
            OP_STR:   o_entry = hdr(i_length, 32'd31, BASE_FIXSTR, LEAD_STR16, LEAD_STR32);
            OP_MAP:   o_entry = hdr(i_length, 32'd15, BASE_FIXMAP, LEAD_MAP16, LEAD_MAP32);
            OP_ARRAY: o_entry = hdr(i_length, 32'd15, BASE_FIXARR, LEAD_ARR16, LEAD_ARR32);
            OP_BIN: begin
                if (i_length <= 32'h0000_00FF) begin
                    o_entry.lead     = LEAD_BIN8;
                    o_entry.body     = {i_length[7:0], 56'd0};
                    o_entry.body_len = 4'd1;
                end else if (i_length <= 32'h0000_FFFF) begin
                    o_entry.lead     = LEAD_BIN16;
                    o_entry.body     = {i_length[15:0], 48'd0};
                    o_entry.body_len = 4'd2;
                end else begin
                    o_entry.lead     = LEAD_BIN32;
                    o_entry.body     = {i_length, 32'd0};
                    o_entry.body_len = 4'd4;
                end
            end
            // unused codes: accept and drop
            default: known = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/mve_queue.sv */
`default_nettype none
module mve_queue
    import mve_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output      logic   o_full,
    output      logic   o_valid,
    output      t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/mve_back.sv */
`default_nettype none
module mve_back
    import mve_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_entry     i_entry,
    output      logic       o_q_pop,
    output      logic       o_m_tvalid,
    input  wire logic       i_m_tready,
    output      logic [7:0] o_m_tdata,
    output      logic       o_m_tlast
);

    logic        r_valid, n_valid;
    logic [71:0] r_sr,    n_sr;
    logic [3:0]  r_cnt,   n_cnt;
    logic        take;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_sr[71:64];
    assign o_m_tlast  = r_cnt == 4'd0;

    assign take    = !r_valid || (i_m_tready && r_cnt == 4'd0);
    assign o_q_pop = take && i_q_valid;

    always_comb begin
        n_valid = r_valid;
        n_sr    = r_sr;
        n_cnt   = r_cnt;
        if (r_valid && i_m_tready && r_cnt != 4'd0) begin
            // advance to the next body byte
            n_sr  = {r_sr[63:0], 8'd0};
            n_cnt = r_cnt - 4'd1;
        end else if (take) begin
            n_valid = i_q_valid;
            n_sr    = {i_entry.lead, i_entry.body};
            n_cnt   = i_entry.body_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr  <= n_sr;
        r_cnt <= n_cnt;
    end

endmodule
`default_nettype wire

/* rtl/msgpack_value_encoder.sv */
// MessagePack value encoder.
// Slave channel: one request per beat. tuser carries the operation code
// (nil, true, false, int, str/bin/map/array header, payload byte); tdata
// carries int_value, length and data_byte. Codes 9..15 are accepted and
// produce nothing.
// Master channel: one encoded byte per beat, most significant first, with
// tlast on the final byte of each request's run (1 to 9 bytes).
// The first byte of a request is registered in the request queue and then
// in the byte serializer before it is valid on the master channel.
// Throughput: while tready is high the output emits one byte per cycle;
// a run holds the byte serializer to its last byte, so one-byte requests
// (payload, fixints, nil/bool) flow at one per cycle. The input takes a
// beat every cycle while the request queue (QUEUE_DEPTH entries) has room.
// Stall: while tready is low the current byte holds, the queue fills and
// then the slave tready drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears the queue and the output valid.
`default_nettype none
module msgpack_value_encoder
    import mve_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output      logic         o_s_tready,
    input  wire logic [103:0] i_s_tdata,   // int_value[63:0], length[95:64], data_byte[103:96]
    input  wire logic [3:0]   i_s_tuser,   // operation[3:0]
    output      logic         o_m_tvalid,
    input  wire logic         i_m_tready,
    output      logic [7:0]   o_m_tdata,   // out_byte[7:0]
    output      logic         o_m_tlast
);

    logic   push, q_full, q_valid, q_pop;
    t_entry f_entry, q_entry;

    mve_front u_front (
        .i_valid     (i_s_tvalid),
        .i_operation (i_s_tuser),
        .i_int_value (i_s_tdata[63:0]),
        .i_length    (i_s_tdata[95:64]),
        .i_data_byte (i_s_tdata[103:96]),
        .i_q_full    (q_full),
        .o_ready     (o_s_tready),
        .o_push      (push),
        .o_entry     (f_entry)
    );

    mve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    mve_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_entry    (q_entry),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

/* tb/tb_msgpack_value_encoder.sv */
module tb_msgpack_value_encoder;
    import mve_pkg::*;

    localparam int ITEM_TARGET = 470;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    class msgpack_scoreboard;
        t_enc_byte   pending[$];
        int unsigned mismatches = 0;

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // push a lead byte and nbytes of body, most significant first
        function void push_run(logic [7:0] lead, logic [63:0] body, int nbytes);
            t_enc_byte b;
            b.data = lead;
            b.last = (nbytes == 0);
            pending.push_back(b);
            for (int i = nbytes - 1; i >= 0; i--) begin
                b.data = body[8*i +: 8];
                b.last = (i == 0);
                pending.push_back(b);
            end
        endfunction

        function void note_request(logic [3:0] op, logic [63:0] ival, logic [31:0] len,
                                   logic [7:0] db);
            logic signed [63:0] v;
            v = ival;
            case (op)
                OP_NIL:   push_run(LEAD_NIL, '0, 0);
                OP_TRUE:  push_run(LEAD_TRUE, '0, 0);
                OP_FALSE: push_run(LEAD_FALSE, '0, 0);
                OP_INT: begin
                    if (v > 0 && v <= 127)
                        push_run(ival[7:0], '0, 0);
                    else if (v < 0 && v >= -31)
                        push_run(BASE_NEGFIX | ival[7:0], '0, 0);
                    else if (v >= -127 && v <= 127)
                        push_run(LEAD_INT8, ival, 1);
                    else if (v >= -32767 && v <= 32767)
                        push_run(LEAD_INT16, ival, 2);
                    else if (v >= -64'sd2147483648 && v <= 64'sd2147483647)
                        push_run(LEAD_INT32, ival, 4);
                    else
                        push_run(LEAD_INT64, ival, 8);
                end
                OP_STR: begin
                    if (len <= 31)
                        push_run(BASE_FIXSTR + len[7:0], '0, 0);
                    else if (len <= 32'hFFFF)
                        push_run(LEAD_STR16, 64'(len), 2);
                    else
                        push_run(LEAD_STR32, 64'(len), 4);
                end
                OP_BIN: begin
                    if (len <= 32'hFF)
                        push_run(LEAD_BIN8, 64'(len), 1);
                    else if (len <= 32'hFFFF)
                        push_run(LEAD_BIN16, 64'(len), 2);
                    else
                        push_run(LEAD_BIN32, 64'(len), 4);
                end
                OP_MAP: begin
                    if (len <= 15)
                        push_run(BASE_FIXMAP + len[7:0], '0, 0);
                    else if (len <= 32'hFFFF)
                        push_run(LEAD_MAP16, 64'(len), 2);
                    else
                        push_run(LEAD_MAP32, 64'(len), 4);
                end
                OP_ARRAY: begin
                    if (len <= 15)
                        push_run(BASE_FIXARR + len[7:0], '0, 0);
                    else if (len <= 32'hFFFF)
                        push_run(LEAD_ARR16, 64'(len), 2);
                    else
                        push_run(LEAD_ARR32, 64'(len), 4);
                end
                OP_PAYLOAD: push_run(db, '0, 0);
                default: ;
            endcase
        endfunction

        task check_byte(logic [7:0] data, logic last);
            t_enc_byte want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
            end else begin
                want = pending.pop_front();
                if (data !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h", data, want.data));
                if (last !== want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b on byte %02h",
                                              last, want.last, want.data));
            end
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [103:0] i_s_tdata;   // int_value[63:0], length[95:64], data_byte[103:96]
    logic [3:0]   i_s_tuser;   // operation[3:0]
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [7:0]   o_m_tdata;   // out_byte[7:0]
    logic         o_m_tlast;

    msgpack_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;

    msgpack_value_encoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_int();
        longint edges [0:12];
        longint v;
        edges = '{0, 127, -31, -32, -127, -128, 32767, -32767, -32768,
                  64'sd2147483647, -64'sd2147483648,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
        case ($urandom_range(0, 4))
            0: v = longint'($urandom_range(0, 255)) - 128;
            1: v = edges[$urandom_range(0, 12)] + longint'($urandom_range(0, 2)) - 1;
            2: v = $signed(rand64()) >>> $urandom_range(0, 63);
            default: v = $signed(rand64());
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_len();
        logic [31:0] edges [0:9];
        logic [31:0] v;
        edges = '{0, 15, 16, 31, 32, 255, 256, 32'hFFFF, 32'h1_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 40);
            1: v = edges[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
            2: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [3:0] op, input logic [63:0] ival,
                             input logic [31:0] len, input logic [7:0] db);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {db, len, ival};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(op, ival, len, db);
        if (op <= OP_PAYLOAD) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // receiver: hold tready in modes of random length
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode = 0;
        mode_left = 0;
        phase = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_byte(o_m_tdata, o_m_tlast);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                2: i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= ((phase % 7) > 2);
            endcase
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [3:0] op;
        int n;
        int count;
        bit paused;
        paused = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= '0;
        i_s_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_NIL, rand64(), $urandom, 8'($urandom));
        send_item(OP_TRUE, rand64(), $urandom, 8'($urandom));
        send_item(OP_FALSE, rand64(), $urandom, 8'($urandom));
        send_item(OP_INT, 64'sd0, $urandom, 8'($urandom));
        send_item(OP_INT, 64'sd1, $urandom, 8'($urandom));
        send_item(OP_INT, 64'sd127, $urandom, 8'($urandom));
        send_item(OP_INT, -64'sd1, $urandom, 8'($urandom));
        send_item(OP_INT, -64'sd31, $urandom, 8'($urandom));
        send_item(OP_INT, -64'sd32, $urandom, 8'($urandom));
        send_item(OP_INT, -64'sd128, $urandom, 8'($urandom));
        send_item(OP_INT, -64'sd32768, $urandom, 8'($urandom));
        send_item(OP_INT, 64'sd2147483647, $urandom, 8'($urandom));
        send_item(OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, 8'($urandom));
        send_item(OP_INT, 64'h8000_0000_0000_0000, $urandom, 8'($urandom));
        send_item(OP_STR, rand64(), 32'd31, 8'($urandom));
        send_item(OP_STR, rand64(), 32'd32, 8'($urandom));
        send_item(OP_STR, rand64(), 32'h1_0000, 8'($urandom));
        send_item(OP_BIN, rand64(), 32'd255, 8'($urandom));
        send_item(OP_BIN, rand64(), 32'd256, 8'($urandom));
        send_item(OP_BIN, rand64(), 32'h1_0000, 8'($urandom));
        send_item(OP_MAP, rand64(), 32'd16, 8'($urandom));
        send_item(OP_MAP, rand64(), 32'hFFFF_FFFF, 8'($urandom));
        send_item(OP_ARRAY, rand64(), 32'd15, 8'($urandom));
        send_item(OP_ARRAY, rand64(), 32'hFFFF, 8'($urandom));
        send_item(OP_PAYLOAD, rand64(), $urandom, 8'hFF);
        send_item(4'd9, rand64(), $urandom, 8'($urandom));
        send_item(4'd15, rand64(), $urandom, 8'($urandom));

        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    op = $urandom_range(0, 1) ? OP_STR : OP_BIN;
                    n = $urandom_range(0, 12);
                    send_item(op, rand64(), n, 8'($urandom));
                    repeat (n) send_item(OP_PAYLOAD, rand64(), $urandom, 8'($urandom));
                end
                3, 4: begin
                    op = $urandom_range(0, 1) ? OP_MAP : OP_ARRAY;
                    n = $urandom_range(0, 5);
                    count = (op == OP_MAP) ? 2 * n : n;
                    send_item(op, rand64(), n, 8'($urandom));
                    repeat (count)
                        send_item(4'($urandom_range(int'(OP_NIL), int'(OP_INT))), pick_int(),
                                  $urandom, 8'($urandom));
                end
                5, 6: send_item(OP_INT, pick_int(), $urandom, 8'($urandom));
                7: send_item(4'($urandom_range(int'(OP_STR), int'(OP_ARRAY))), rand64(),
                             pick_len(), 8'($urandom));
                default: send_item(4'($urandom_range(0, 15)), pick_int(), pick_len(),
                                   8'($urandom));
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* msgpack_value_encoder.f */
rtl/mve_pkg.sv
rtl/mve_front.sv
rtl/mve_queue.sv
rtl/mve_back.sv
rtl/msgpack_value_encoder.sv
tb/tb_msgpack_value_encoder.sv
